// ===== hw/rtl/dojq_pkg.sv =====
// Shared constants, types and codes for the deadline ordered job queue.
package dojq_pkg;

  localparam int Depth = 16;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int DueW  = 33;
  localparam int TagW  = 8;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpDelete = 2'd1;
  localparam logic [1:0] OpTick   = 2'd2;

  typedef enum logic [2:0] {
    StInserted = 3'd0,
    StPopped   = 3'd1,
    StNotDue   = 3'd2,
    StEmpty    = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CtIdle,
    CtHeadRd,
    CtShift,
    CtPlace,
    CtResult
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  job_tag;
    logic [31:0] submit_time;
    logic [23:0] start_delay;
    logic [31:0] now_time;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  popped_tag;
    logic [32:0] popped_due;
    logic [4:0]  job_count;
  } out_word_t;

  typedef struct packed {
    logic [DueW-1:0] due;
    logic [TagW-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/dojq_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module dojq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/dojq_ctrl.sv =====
// Sequencer: decodes commands, walks the circular job memory, builds results.
module dojq_ctrl
  import dojq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  in_word_t  cmd_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_word_t res_o,
  output ram_req_t  ram_req_o,
  input  entry_t    ram_rdata_i
);

  ctrl_state_e     state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] walk_q, walk_d;
  logic [CntW-1:0] left_q, left_d;
  logic [DueW-1:0] new_due_q, new_due_d;
  logic [TagW-1:0] new_tag_q, new_tag_d;
  logic [1:0]      op_q, op_d;
  logic [31:0]     now_q, now_d;
  out_word_t       res_q, res_d;

  logic            start;
  logic [DueW-1:0] due_sum;
  logic            head_due;
  entry_t          new_entry;

  function automatic logic [IdxW-1:0] idx_add(logic [IdxW-1:0] base, logic [CntW-1:0] off);
    logic [IdxW+1:0] s;
    s = (IdxW+2)'(base) + (IdxW+2)'(off);
    if (s >= (IdxW+2)'(Depth)) begin
      s = s - (IdxW+2)'(Depth);
    end
    return s[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] idx_inc(logic [IdxW-1:0] i);
    return (i == IdxW'(Depth - 1)) ? '0 : i + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(Depth - 1) : i - IdxW'(1);
  endfunction

  assign due_sum   = {1'b0, cmd_i.submit_time} + {9'b0, cmd_i.start_delay};
  assign head_due  = ({1'b0, now_q} >= ram_rdata_i.due);
  assign new_entry = '{due: new_due_q, tag: new_tag_q};
  assign start     = cmd_valid_i && cmd_ready_o;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    walk_d      = walk_q;
    left_d      = left_q;
    new_due_d   = new_due_q;
    new_tag_d   = new_tag_q;
    op_d        = op_q;
    now_d       = now_q;
    res_d       = res_q;
    ram_req_o   = '0;
    res_valid_o = 1'b0;
    cmd_ready_o = 1'b0;

    unique case (state_q)
      CtIdle: begin
        cmd_ready_o = 1'b1;
      end
      CtHeadRd: begin
        state_d = CtResult;
        if (op_q == OpDelete || head_due) begin
          head_d = idx_inc(head_q);
          count_d = count_q - CntW'(1);
          res_d = '{status: StPopped, popped_tag: ram_rdata_i.tag,
                    popped_due: ram_rdata_i.due, job_count: 5'(count_q - CntW'(1))};
        end else begin
          res_d = '{status: StNotDue, popped_tag: '0, popped_due: '0,
                    job_count: 5'(count_q)};
        end
      end
      CtShift: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_inc(walk_q);
        if (ram_rdata_i.due >= new_due_q) begin
          // move a job due at or after the new one up one slot and keep walking towards the head
          ram_req_o.wdata = ram_rdata_i;
          if (left_q == CntW'(1)) begin
            state_d = CtPlace;
          end else begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = idx_dec(walk_q);
            walk_d = idx_dec(walk_q);
            left_d = left_q - CntW'(1);
          end
        end else begin
          ram_req_o.wdata = new_entry;
          count_d = count_q + CntW'(1);
          res_d = '{status: StInserted, popped_tag: '0, popped_due: '0,
                    job_count: 5'(count_q + CntW'(1))};
          state_d = CtResult;
        end
      end
      CtPlace: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = walk_q;
        ram_req_o.wdata = new_entry;
        count_d = count_q + CntW'(1);
        res_d = '{status: StInserted, popped_tag: '0, popped_due: '0,
                  job_count: 5'(count_q + CntW'(1))};
        state_d = CtResult;
      end
      CtResult: begin
        res_valid_o = 1'b1;
        cmd_ready_o = res_ready_i;
        if (res_ready_i) begin
          state_d = CtIdle;
        end
      end
      default: begin
        state_d = CtIdle;
      end
    endcase

    if (start) begin
      new_due_d = due_sum;
      new_tag_d = cmd_i.job_tag;
      op_d      = cmd_i.opcode;
      now_d     = cmd_i.now_time;
      if (cmd_i.opcode == OpInsert) begin
        if (count_q == CntW'(Depth)) begin
          res_d = '{status: StFull, popped_tag: '0, popped_due: '0,
                    job_count: 5'(count_q)};
          state_d = CtResult;
        end else if (count_q == '0) begin
          walk_d  = head_q;
          state_d = CtPlace;
        end else begin
          walk_d  = idx_add(head_q, count_q - CntW'(1));
          left_d  = count_q;
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_add(head_q, count_q - CntW'(1));
          state_d = CtShift;
        end
      end else if (count_q == '0) begin
        res_d = '{status: StEmpty, popped_tag: '0, popped_due: '0, job_count: '0};
        state_d = CtResult;
      end else begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = head_q;
        state_d = CtHeadRd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtIdle;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q    <= walk_d;
    left_q    <= left_d;
    new_due_q <= new_due_d;
    new_tag_q <= new_tag_d;
    op_q      <= op_d;
    now_q     <= now_d;
    res_q     <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/deadline_ordered_job_queue_top.sv =====
// Top level of the deadline ordered job queue: sequencer, job memory, result register.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-----------
//   in      | input     | in_valid_i / in_ready_o  | in_word_t
//   out     | output    | out_valid_o / out_ready_i| out_word_t
//
// Delete and tick read the head from memory, then compare and pop (tick pops only a due head).
// An insert moves every stored job due at or after the new one up one slot, then writes
// the new one: the sequencer moves one entry per cycle through the single write port.
// A refused insert, or a delete or tick on an empty queue, goes straight to its result.
// After reset the queue is empty; the job memory is not cleared, only the count and head.
// A result waiting in the output register does not stop the next word being taken.
module deadline_ordered_job_queue_top
  import dojq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic      res_valid;
  logic      res_ready;
  out_word_t res_word;
  ram_req_t  ram_req;
  entry_t    ram_rdata;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  // The sequencer owns pointers, count and command decode.
  dojq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_valid_i),
    .cmd_ready_o (in_ready_o),
    .cmd_i       (in_word_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res_word),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Jobs live in a circular buffer sorted from head by due time.
  dojq_ram #(
    .Width ($bits(entry_t)),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: take a new result whenever the slot is empty or draining.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the word while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== hw/rtl/dojq_checker.sv =====
// Port-level checks for the deadline ordered job queue, bound to the top level.
module dojq_checker
  import dojq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("command word changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_no_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != StPopped
      |-> out_word_o.popped_tag == '0 && out_word_o.popped_due == '0)
    else $error("tag or due set on a result without a pop");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == StFull |-> out_word_o.job_count == 5'(Depth))
    else $error("full refusal with count short of depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == StEmpty |-> out_word_o.job_count == '0)
    else $error("empty status with jobs held");

endmodule

bind deadline_ordered_job_queue_top dojq_checker u_dojq_checker (.*);
